>>> hw/rtl/skbh_pkg.sv
package skbh_pkg;

	// Field and state widths
	localparam int unsigned HASH_W = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NB_W   = 32;

	// djb2 seed and multiplier shift (hash*33 = (hash << 5) + hash)
	localparam logic [HASH_W-1:0] HASH_SEED  = HASH_W'(5381);
	localparam int unsigned       HASH_SHIFT = 5;

	// Remainder unit: one quotient bit per step
	localparam int unsigned DIV_STEPS = HASH_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Status of the remainder unit towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/skbh_if.sv
interface skbh_key_if;
	import skbh_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] key_byte;
	logic              byte_present;
	logic              key_end;

	modport source (output valid, output key_byte, output byte_present, output key_end,
		input ready);
	modport sink (input valid, input key_byte, input byte_present, input key_end,
		output ready);
endinterface

interface skbh_bucket_if;
	import skbh_pkg::*;

	logic            valid;
	logic            ready;
	logic [NB_W-1:0] bucket_index;

	modport source (output valid, output bucket_index, input ready);
	modport sink (input valid, input bucket_index, output ready);
endinterface

interface skbh_cfg_if;
	import skbh_pkg::*;

	logic            valid;
	logic            ready;
	logic [NB_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/skbh_div.sv
module skbh_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [skbh_pkg::HASH_W-1:0]  dividend,
	input  logic [skbh_pkg::NB_W-1:0]    divisor,
	output skbh_pkg::div_stat_t          stat,
	output logic [skbh_pkg::NB_W-1:0]    remainder
);
	import skbh_pkg::*;

	logic [HASH_W-1:0]    dvd_q;
	logic [NB_W-1:0]      dvs_q;
	logic [NB_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NB_W:0]        shifted;
	logic [NB_W+1:0]      diff;

	// Bring down the next dividend bit and trial-subtract the divisor
	assign shifted = {rem_q, dvd_q[HASH_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// Sequence control: one step per cycle, done pulses after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring remainder, keep partial remainder below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!diff[NB_W+1]) begin
				rem_q <= diff[NB_W-1:0];
			end else begin
				rem_q <= shifted[NB_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

>>> hw/rtl/string_key_bucket_hash_core.sv
// djb2 bucket hash over a key streamed one byte per transfer.
//
// key_ch   : one transfer per key byte (key_byte, byte_present, key_end).
//            A byte with byte_present set is folded in as a signed char:
//            hash = hash*33 + byte, modulo 2^64. key_end marks the last
//            transfer of a key; byte_present clear with key_end set ends the
//            key without adding a byte.
// bucket_ch: one transfer per key, bucket_index = hash mod num_buckets
//            (0 when num_buckets is 0).
// cfg      : writes num_buckets; always ready. Write only while idle.
//
// Flow: transfers without key_end are taken while idle. A transfer with
// key_end starts the bit-serial remainder unit, one quotient bit per
// step; key_ch is not ready meanwhile. The bucket index is loaded into
// the output register once the remainder unit is done and the slot is free.
// A stalled bucket_ch holds the result in the output register; a second key
// may then be hashed and divided, and waits for the slot before reloading.
// Reset: hash returns to 5381, num_buckets to 64, output slot empty.
module string_key_bucket_hash_core (
	input  logic          clk,
	input  logic          arst_n,
	skbh_key_if.sink      key_ch,
	skbh_bucket_if.source bucket_ch,
	skbh_cfg_if.sink      cfg
);
	import skbh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t            state_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_next;
	logic [HASH_W-1:0] byte_ext;
	logic [NB_W-1:0]   num_buckets_q;
	logic [NB_W-1:0]   out_q;
	logic              out_vld_q;
	logic              key_xfer;
	logic              div_start;
	logic              slot_free;
	logic              load_out;
	div_stat_t         div_stat;
	logic [NB_W-1:0]   div_rem;

	assign key_ch.ready = (state_q == ST_IDLE);
	assign key_xfer     = key_ch.valid && key_ch.ready;
	assign div_start    = key_xfer && key_ch.key_end;
	assign slot_free    = !out_vld_q || bucket_ch.ready;
	assign load_out     = slot_free && ((state_q == ST_DIV && div_stat.done)
		|| state_q == ST_WAIT);

	// Fold in the byte as a sign-extended char: hash*33 + byte
	assign byte_ext  = {{(HASH_W-BYTE_W){key_ch.key_byte[BYTE_W-1]}}, key_ch.key_byte};
	assign hash_next = key_ch.byte_present ? ((hash_q << HASH_SHIFT) + hash_q + byte_ext)
		: hash_q;

	skbh_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (hash_next),
		.divisor   (num_buckets_q),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (div_start) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= slot_free ? ST_IDLE : ST_WAIT;
				end
				ST_WAIT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Accumulator: advance on each byte, back to the seed at key end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (key_xfer) begin
			hash_q <= key_ch.key_end ? HASH_SEED : hash_next;
		end
	end

	// Bucket count register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buckets_q <= NB_W'(64);
		end else if (cfg.valid && cfg.ready) begin
			num_buckets_q <= cfg.data;
		end
	end

	// Output slot: hold until transfer, load when the remainder is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (bucket_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= (num_buckets_q == '0) ? '0 : div_rem;
		end
	end

	assign bucket_ch.valid        = out_vld_q;
	assign bucket_ch.bucket_index = out_q;

`ifndef ASSERT_OFF
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("remainder done outside divide state");

	a_busy_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("remainder unit busy outside divide state");

	a_seed_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(key_ch.valid && key_ch.ready && key_ch.key_end) |=> hash_q == HASH_SEED)
		else $error("accumulator not reseeded after key end");

	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bucket_ch.valid) |-> $past(state_q == ST_DIV || state_q == ST_WAIT))
		else $error("bucket result without a finished remainder");
`endif

endmodule

>>> tb/string_key_bucket_hash_core_tb.sv
module string_key_bucket_hash_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skbh_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 80;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS    = 175;
	localparam int unsigned NUM_PHASES     = 8;
	localparam int unsigned NUM_DIRECTED   = 24;
	localparam logic [NB_W-1:0] RESET_BUCKETS = NB_W'(64);

	typedef enum bit {
		ROW_KEY,
		ROW_CFG
	} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [BYTE_W-1:0] key_byte;
		bit                present;
		bit                last;
		logic [NB_W-1:0]   cfg_data;
		bit                typed;
		logic [NB_W-1:0]   exp_bucket;
	} dir_row_t;

	logic clk;
	logic arst_n;

	skbh_key_if    key_ch();
	skbh_bucket_if bucket_ch();
	skbh_cfg_if    cfg();

	string_key_bucket_hash_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_ch    (key_ch),
		.bucket_ch (bucket_ch),
		.cfg       (cfg)
	);

	// Predicted hash state and register copy
	logic [HASH_W-1:0] djb2_acc;
	logic [NB_W-1:0]   bucket_count;
	logic [NB_W-1:0]   bucket_exp_q [$];

	int unsigned error_count  = 0;
	int unsigned idle_cycles  = 0;
	int unsigned rx_hold_req  = 0;
	int unsigned rx_hold_left = 0;
	bit          no_gaps      = 1'b0;

	// Directed keys: extremes of the byte, empty keys, ignored items, register extremes
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{ROW_KEY, 8'h00, 1'b0, 1'b1, 32'h0, 1'b1, 32'd5},
		'{ROW_KEY, 8'h00, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h7F, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h80, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'hFF, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'hA5, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h5A, 1'b0, 1'b1, 32'h0, 1'b1, 32'd5},
		'{ROW_KEY, 8'h41, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h00, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h61, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h62, 1'b1, 1'b1, 32'h0, 1'b1, 32'd0},
		'{ROW_KEY, 8'h00, 1'b0, 1'b1, 32'h0, 1'b1, 32'd0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, 32'h1, 1'b0, 32'h0},
		'{ROW_KEY, 8'hC3, 1'b1, 1'b1, 32'h0, 1'b1, 32'd0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_KEY, 8'hFF, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'hFF, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'hFF, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h7F, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, 32'h8000_0000, 1'b0, 32'h0},
		'{ROW_KEY, 8'h80, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h01, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
		'{ROW_KEY, 8'h00, 1'b0, 1'b1, 32'h0, 1'b1, 32'd5381}
	};

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Fold one key transfer into the hash; give the bucket on key end
	function automatic void fold_key_item(input logic [BYTE_W-1:0] kb, input bit present,
		input bit last, output bit has_bucket, output logic [NB_W-1:0] bucket);
		logic [HASH_W-1:0] wide;
		wide       = '0;
		bucket     = '0;
		has_bucket = last;
		if (present) begin
			djb2_acc = (djb2_acc << HASH_SHIFT) + djb2_acc
				+ {{(HASH_W-BYTE_W){kb[BYTE_W-1]}}, kb};
		end
		if (last) begin
			if (bucket_count != '0) begin
				wide   = djb2_acc % {{(HASH_W-NB_W){1'b0}}, bucket_count};
				bucket = wide[NB_W-1:0];
			end
			djb2_acc = HASH_SEED;
		end
	endfunction

	// Offer one key transfer, with random gaps in front of it
	task automatic offer_key_item(input logic [BYTE_W-1:0] kb, input bit present,
		input bit last, input bit typed, input logic [NB_W-1:0] typed_bucket);
		bit              has_bucket;
		logic [NB_W-1:0] bucket;
		while (!no_gaps && $urandom_range(0, 99) < 19) begin
			key_ch.valid <= 1'b0;
			@(posedge clk);
		end
		key_ch.valid        <= 1'b1;
		key_ch.key_byte     <= kb;
		key_ch.byte_present <= present;
		key_ch.key_end      <= last;
		do @(posedge clk); while (!key_ch.ready);
		fold_key_item(kb, present, last, has_bucket, bucket);
		if (has_bucket)
			bucket_exp_q.push_back(typed ? typed_bucket : bucket);
	endtask

	// Drop valid and wait for every expected bucket, then let the block settle
	task automatic wait_buckets_drained(input int unsigned settle);
		key_ch.valid <= 1'b0;
		while (bucket_exp_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_bucket_count(input logic [NB_W-1:0] nb);
		cfg.valid <= 1'b1;
		cfg.data  <= nb;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid    <= 1'b0;
		bucket_count = nb;
	endtask

	// One random key: mostly short, sometimes long enough to wrap the hash
	task automatic send_random_key(output int unsigned n_items);
		int unsigned len;
		bit          end_on_byte;
		n_items     = 0;
		len         = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
			: $urandom_range(9, 40);
		end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				offer_key_item(BYTE_W'($urandom), 1'b0, 1'b0, 1'b0, '0);
				n_items++;
			end
			offer_key_item(BYTE_W'($urandom), 1'b1, end_on_byte && (i == len - 1), 1'b0, '0);
			n_items++;
		end
		if (!end_on_byte) begin
			offer_key_item(BYTE_W'($urandom), 1'b0, 1'b1, 1'b0, '0);
			n_items++;
		end
	endtask

	// Bucket receiver: check each transfer, drive ready with stalls and hold-offs
	initial begin
		logic [NB_W-1:0] want;
		bucket_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (bucket_ch.valid && bucket_ch.ready) begin
				if (bucket_exp_q.size() == 0) begin
					$display("%0t: unexpected bucket_index, actual %h", $time,
						bucket_ch.bucket_index);
					error_count++;
				end else begin
					want = bucket_exp_q.pop_front();
					if (bucket_ch.bucket_index !== want) begin
						$display("%0t: bucket_index mismatch, expected %h actual %h", $time,
							want, bucket_ch.bucket_index);
						error_count++;
					end
				end
			end
			if (rx_hold_req != 0) begin
				rx_hold_left = rx_hold_req;
				rx_hold_req  = 0;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				bucket_ch.ready <= 1'b0;
			end else if (no_gaps) begin
				bucket_ch.ready <= 1'b1;
			end else begin
				bucket_ch.ready <= ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if ((key_ch.valid && key_ch.ready) || (bucket_ch.valid && bucket_ch.ready)
			|| (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int unsigned     n_items;
		int unsigned     phase_items;
		bit              paused;
		logic [NB_W-1:0] nb;
		arst_n              = 1'b0;
		key_ch.valid        = 1'b0;
		key_ch.key_byte     = '0;
		key_ch.byte_present = 1'b0;
		key_ch.key_end      = 1'b0;
		cfg.valid           = 1'b0;
		cfg.data            = '0;
		djb2_acc            = HASH_SEED;
		bucket_count        = RESET_BUCKETS;
		paused              = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_buckets_drained(SETTLE_CYCLES);
				write_bucket_count(directed_rows[i].cfg_data);
			end else begin
				offer_key_item(directed_rows[i].key_byte, directed_rows[i].present,
					directed_rows[i].last, directed_rows[i].typed,
					directed_rows[i].exp_bucket);
			end
		end

		// Random keys over several bucket counts
		for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: nb = NB_W'($urandom);
				1: nb = NB_W'(1);
				2: nb = '1;
				3: nb = NB_W'($urandom_range(2, 17));
				4: nb = NB_W'(1) << $urandom_range(0, NB_W - 1);
				5: nb = '0;
				6: nb = NB_W'($urandom_range(1, 1000));
				default: nb = NB_W'($urandom);
			endcase
			wait_buckets_drained(SETTLE_CYCLES);
			write_bucket_count(nb);
			no_gaps     = (phase == 3);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				// Hold the receiver off while keys keep coming
				if (phase == 2 && phase_items == 0)
					rx_hold_req = RX_HOLD_CYCLES;
				// Pause the sender until every bucket is back
				if (phase == 4 && !paused && phase_items >= PHASE_ITEMS / 2) begin
					wait_buckets_drained(0);
					paused = 1'b1;
				end
				send_random_key(n_items);
				phase_items += n_items;
			end
		end
		no_gaps = 1'b0;

		wait_buckets_drained(SETTLE_CYCLES);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
